// ----- design/rcw_pkg.sv -----
// ----------------------------------------------------------------------------
// rcw_pkg: shared types and constants of the Reno congestion window block
// Field widths, event and phase codes, configuration register indexes and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rcw_pkg;

    localparam int FLD_W      = 32;
    localparam int WIN_W      = 17;
    localparam int DUP_W      = 16;
    localparam int MARGIN_W   = 14;
    localparam int EV_W       = 3;
    localparam int PH_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [WIN_W-1:0]    INIT_THR_RST = 17'd65536;
    localparam logic [MARGIN_W-1:0] MARGIN_RST   = 14'd1024;
    localparam logic [DUP_W-1:0]    DUP_THIRD    = 16'd3;
    localparam logic [DUP_W-1:0]    DUP_SAT      = 16'hFFFF;

    localparam logic OP_ACK     = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_THR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN   = 1'd1;

    typedef enum logic [EV_W-1:0] {
        EV_NEW     = 3'd0,
        EV_TIMEOUT = 3'd1,
        EV_DUP     = 3'd2,
        EV_DUP3    = 3'd3,
        EV_OVER    = 3'd4
    } t_event;

    typedef enum logic [PH_W-1:0] {
        PH_SS = 2'd0,
        PH_FR = 2'd1,
        PH_CA = 2'd2
    } t_phase;

    typedef struct packed {
        logic             operation;
        logic [FLD_W-1:0] ack_seq;
        logic [FLD_W-1:0] ack_len;
        logic [FLD_W-1:0] ack_offset;
        logic [FLD_W-1:0] ack_total;
    } t_evt_item;

    typedef struct packed {
        logic [EV_W-1:0]  event_code;
        logic [PH_W-1:0]  phase;
        logic [WIN_W-1:0] window;
        logic [WIN_W-1:0] threshold;
        logic [DUP_W-1:0] dup_count;
        logic             clear_inflight;
        logic             retransmit;
        logic [FLD_W-1:0] resend_seq;
        logic [FLD_W-1:0] resend_offset;
        logic [FLD_W-1:0] delivered_bytes;
        logic             unexpected;
    } t_res_item;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic classify;
        logic start_div;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ----- design/rcw_evt_if.sv -----
// ----------------------------------------------------------------------------
// rcw_evt_if: event channel
// Valid/ready channel carrying one ACK or timeout event per transfer.
// ----------------------------------------------------------------------------
interface rcw_evt_if;
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [rcw_pkg::FLD_W-1:0] ack_seq;
    logic [rcw_pkg::FLD_W-1:0] ack_len;
    logic [rcw_pkg::FLD_W-1:0] ack_offset;
    logic [rcw_pkg::FLD_W-1:0] ack_total;

    modport source (
        output valid, operation, ack_seq, ack_len, ack_offset, ack_total,
        input  ready
    );
    modport sink (
        input  valid, operation, ack_seq, ack_len, ack_offset, ack_total,
        output ready
    );
endinterface

// ----- design/rcw_res_if.sv -----
// ----------------------------------------------------------------------------
// rcw_res_if: result channel
// Valid/ready channel carrying one window update per transfer.
// ----------------------------------------------------------------------------
interface rcw_res_if;
    logic                      valid;
    logic                      ready;
    logic [rcw_pkg::EV_W-1:0]  event_code;
    logic [rcw_pkg::PH_W-1:0]  phase;
    logic [rcw_pkg::WIN_W-1:0] window;
    logic [rcw_pkg::WIN_W-1:0] threshold;
    logic [rcw_pkg::DUP_W-1:0] dup_count;
    logic                      clear_inflight;
    logic                      retransmit;
    logic [rcw_pkg::FLD_W-1:0] resend_seq;
    logic [rcw_pkg::FLD_W-1:0] resend_offset;
    logic [rcw_pkg::FLD_W-1:0] delivered_bytes;
    logic                      unexpected;

    modport source (
        output valid, event_code, phase, window, threshold, dup_count,
               clear_inflight, retransmit, resend_seq, resend_offset,
               delivered_bytes, unexpected,
        input  ready
    );
    modport sink (
        input  valid, event_code, phase, window, threshold, dup_count,
               clear_inflight, retransmit, resend_seq, resend_offset,
               delivered_bytes, unexpected,
        output ready
    );
endinterface

// ----- design/rcw_div.sv -----
// ----------------------------------------------------------------------------
// rcw_div: bit-serial restoring divider
// One quotient bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module rcw_div #(
    parameter int DVD_W = 21,
    parameter int DVS_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W:0]   r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   shifted;
    logic             fits;
    logic [DVS_W:0]   n_rem;
    logic [DVD_W-1:0] n_quo;

    always_comb begin
        shifted = {r_rem[DVS_W-1:0], r_quo[DVD_W-1]};
        fits    = shifted >= {1'b0, r_dvs};
        n_rem   = fits ? shifted - {1'b0, r_dvs} : shifted;
        n_quo   = {r_quo[DVD_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

`ifndef NO_ASSERTIONS
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < {1'b0, r_dvs}))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ----- design/rcw_dp.sv -----
// ----------------------------------------------------------------------------
// rcw_dp: congestion window datapath
// Holds the window state and configuration, classifies the captured event,
// runs the avoidance increment divide and loads the result register.
// ----------------------------------------------------------------------------
module rcw_dp #(
    parameter int MSS_BYTES = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rcw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rcw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  rcw_pkg::t_evt_item               i_item,
    input  rcw_pkg::t_cmd                    i_cmd,
    output rcw_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rcw_pkg::t_res_item               o_result
);
    import rcw_pkg::*;

    localparam int MSS_SQ = MSS_BYTES * MSS_BYTES;
    localparam int QUO_W  = $clog2(MSS_SQ + 1);
    localparam int GROW_W = ((QUO_W > WIN_W) ? QUO_W : WIN_W) + 1;
    localparam logic [WIN_W-1:0] MSS_W  = WIN_W'(MSS_BYTES);
    localparam logic [WIN_W-1:0] MSS_X3 = WIN_W'(3 * MSS_BYTES);

    // configuration
    logic [WIN_W-1:0]    r_init_thr;
    logic [MARGIN_W-1:0] r_margin;

    // architectural state
    t_phase           r_phase;
    logic [WIN_W-1:0] r_win;
    logic [WIN_W-1:0] r_thr;
    logic [DUP_W-1:0] r_dup;
    logic [FLD_W-1:0] r_last_seq;
    logic [FLD_W-1:0] r_last_len;
    logic [FLD_W-1:0] r_last_off;
    logic [FLD_W-1:0] r_last_tot;
    logic             r_flag;

    // per-item working registers
    t_evt_item r_item;
    t_event    r_ev;
    t_phase    r_ph;
    logic      r_out_valid;
    t_res_item r_res;

    t_phase           ph_c;
    t_event           ev_c;
    logic             ack_match;
    logic             div_done;
    logic [QUO_W-1:0] quo;
    logic [WIN_W-1:0] divisor;

    logic [GROW_W-1:0] inc;
    logic [GROW_W-1:0] grown;
    logic [WIN_W-1:0]  clamp_val;
    logic [WIN_W-1:0]  grow_win;
    logic [WIN_W-1:0]  half_win;

    t_phase           n_phase;
    logic [WIN_W-1:0] n_win;
    logic [WIN_W-1:0] n_thr;
    logic [DUP_W-1:0] n_dup;
    logic             n_flag;
    logic             n_clr;
    logic             n_rtx;
    logic             n_take;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_thr <= INIT_THR_RST;
            r_margin   <= MARGIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INIT_THR: r_init_thr <= i_cfg_data;
                CFG_MARGIN:   r_margin   <= i_cfg_data[MARGIN_W-1:0];
            endcase
        end
    end

    // classify
    always_comb begin
        unique case (r_phase)
            PH_FR:   ph_c = PH_FR;
            PH_CA:   ph_c = PH_CA;
            default: ph_c = PH_SS;
        endcase
        ack_match = (r_item.ack_seq == r_last_seq) && (r_item.ack_len == r_last_len)
                 && (r_item.ack_offset == r_last_off) && (r_item.ack_total == r_last_tot);
        priority if (r_item.operation == OP_TIMEOUT) begin
            ev_c = EV_TIMEOUT;
        end else if (r_win >= r_thr) begin
            ev_c = EV_OVER;
        end else if (r_dup == DUP_THIRD) begin
            ev_c = EV_DUP3;
        end else if (ack_match) begin
            ev_c = EV_DUP;
        end else begin
            ev_c = EV_NEW;
        end
    end

    assign divisor = (r_win == '0) ? WIN_W'(1) : r_win;

    rcw_div #(
        .DVD_W (QUO_W),
        .DVS_W (WIN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (QUO_W'(MSS_SQ)),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // window growth with clamp to threshold minus margin
    always_comb begin
        inc       = (r_ev == EV_NEW && r_ph == PH_CA) ? GROW_W'(quo) : GROW_W'(MSS_BYTES);
        grown     = GROW_W'(r_win) + inc;
        clamp_val = (r_thr > WIN_W'(r_margin)) ? r_thr - WIN_W'(r_margin) : WIN_W'(1);
        if (grown >= GROW_W'(r_thr)) begin
            grow_win = clamp_val;
        end else if (grown[WIN_W-1:0] == '0) begin
            grow_win = WIN_W'(1);
        end else begin
            grow_win = grown[WIN_W-1:0];
        end
        half_win = r_win >> 1;
    end

    // update table
    always_comb begin
        n_phase = r_ph;
        n_win   = r_win;
        n_thr   = r_thr;
        n_dup   = r_dup;
        n_flag  = r_flag;
        n_clr   = 1'b0;
        n_rtx   = 1'b0;
        n_take  = 1'b0;
        unique case (r_ev)
            EV_NEW: begin
                n_take = 1'b1;
                n_clr  = 1'b1;
                n_dup  = '0;
                if (r_ph == PH_FR) begin
                    n_win   = (r_thr == '0) ? WIN_W'(1) : r_thr;
                    n_phase = PH_CA;
                end else begin
                    n_win = grow_win;
                end
            end
            EV_TIMEOUT: begin
                n_thr   = half_win;
                n_win   = MSS_W;
                n_dup   = '0;
                n_rtx   = 1'b1;
                n_clr   = 1'b1;
                n_phase = PH_SS;
            end
            EV_DUP: begin
                if (r_ph == PH_FR) begin
                    n_win = grow_win;
                    n_clr = 1'b1;
                end else begin
                    if (r_dup != DUP_SAT) begin
                        n_dup = r_dup + DUP_W'(1);
                    end
                    n_rtx = 1'b1;
                end
            end
            EV_DUP3: begin
                n_rtx = 1'b1;
                if (r_ph == PH_FR) begin
                    n_flag = 1'b1;
                end else begin
                    n_thr   = half_win;
                    n_win   = half_win + MSS_X3;
                    n_clr   = 1'b1;
                    n_phase = PH_FR;
                end
            end
            default: begin
                if (r_ph == PH_SS) begin
                    n_win   = MSS_W;
                    n_thr   = r_init_thr;
                    n_dup   = '0;
                    n_clr   = 1'b1;
                    n_phase = PH_CA;
                end else begin
                    n_flag = 1'b1;
                end
            end
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.classify) begin
            r_ev <= ev_c;
            r_ph <= ph_c;
        end
        if (i_cmd.commit) begin
            r_res.event_code      <= r_ev;
            r_res.phase           <= n_phase;
            r_res.window          <= n_win;
            r_res.threshold       <= n_thr;
            r_res.dup_count       <= n_dup;
            r_res.clear_inflight  <= n_clr;
            r_res.retransmit      <= n_rtx;
            r_res.resend_seq      <= (n_take ? r_item.ack_seq : r_last_seq) + FLD_W'(1);
            r_res.resend_offset   <= n_take ? r_item.ack_offset : r_last_off;
            r_res.delivered_bytes <= n_take ? r_item.ack_total : r_last_tot;
            r_res.unexpected      <= n_flag;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SS;
            r_win       <= MSS_W;
            r_thr       <= INIT_THR_RST;
            r_dup       <= '0;
            r_last_seq  <= '0;
            r_last_len  <= '0;
            r_last_off  <= '0;
            r_last_tot  <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_phase     <= n_phase;
                r_win       <= n_win;
                r_thr       <= n_thr;
                r_dup       <= n_dup;
                r_flag      <= n_flag;
                r_out_valid <= 1'b1;
                if (n_take) begin
                    r_last_seq <= r_item.ack_seq;
                    r_last_len <= r_item.ack_len;
                    r_last_off <= r_item.ack_offset;
                    r_last_tot <= r_item.ack_total;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.need_div = (ev_c == EV_NEW) && (ph_c == PH_CA);
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_result       = r_res;

`ifndef NO_ASSERTIONS
    a_window_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_win != '0)
        else $error("congestion window reached zero");
    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.commit))
        else $error("result appeared without a commit");
`endif

endmodule

// ----- design/rcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// rcw_ctrl: congestion window sequencer
// Steps each event through capture, classify, optional divide and commit.
// ----------------------------------------------------------------------------
module rcw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rcw_pkg::t_sts i_sts,
    output rcw_pkg::t_cmd o_cmd
);
    import rcw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CLASS  = 4'b0010,
        S_DIV    = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        o_cmd.capture   = 1'b0;
        o_cmd.classify  = 1'b0;
        o_cmd.start_div = 1'b0;
        o_cmd.commit    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CLASS;
                end
            end
            S_CLASS: begin
                o_cmd.classify = 1'b1;
                if (i_sts.need_div) begin
                    o_cmd.start_div = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // hold until the result register is free
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

`ifndef NO_ASSERTIONS
    a_accept_to_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_CLASS))
        else $error("accepted event not classified next");
    a_commit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) && i_sts.out_free |=> (r_state == S_IDLE))
        else $error("commit did not return to idle");
`endif

endmodule

// ----- design/reno_congestion_window_fsm_top.sv -----
// ----------------------------------------------------------------------------
// reno_congestion_window_fsm_top: Reno congestion window controller
// Takes one ACK or timeout event per transfer on i_evt and returns one
// update per event on o_res: the event class, the new phase, window,
// threshold and duplicate count, the in-flight clear and retransmit strobes,
// the resend point taken from the last distinct ACK and a sticky flag for
// events that the phase does not allow. Each event steps through capture,
// classify and commit before the next is taken; a new ACK in congestion
// avoidance also needs MSS*MSS/window, which a bit-serial divider forms
// one quotient bit a cycle between classify and commit. A finished
// update sits in the output register while the next event is already
// taken; the block only stalls at commit if that register is still full.
// Write initial_threshold (index 0) and clamp_margin (index 1) while idle;
// a threshold write does not change the live threshold until the window
// over threshold event reloads it.
// ----------------------------------------------------------------------------
module reno_congestion_window_fsm_top #(
    parameter int MSS_BYTES = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rcw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rcw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rcw_evt_if.sink                        i_evt,
    rcw_res_if.source                      o_res
);
    import rcw_pkg::*;

    t_evt_item w_item;
    t_res_item w_res;
    t_cmd      w_cmd;
    t_sts      w_sts;
    logic      w_in_ready;

    // pack the incoming transfer
    assign w_item.operation  = i_evt.operation;
    assign w_item.ack_seq    = i_evt.ack_seq;
    assign w_item.ack_len    = i_evt.ack_len;
    assign w_item.ack_offset = i_evt.ack_offset;
    assign w_item.ack_total  = i_evt.ack_total;
    assign i_evt.ready       = w_in_ready;

    // sequencer: capture, classify, divide when needed, commit
    rcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_evt.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // state, classification, divider and result register
    rcw_dp #(
        .MSS_BYTES (MSS_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_result    (w_res)
    );

    // unpack the outgoing transfer
    assign o_res.event_code      = w_res.event_code;
    assign o_res.phase           = w_res.phase;
    assign o_res.window          = w_res.window;
    assign o_res.threshold       = w_res.threshold;
    assign o_res.dup_count       = w_res.dup_count;
    assign o_res.clear_inflight  = w_res.clear_inflight;
    assign o_res.retransmit      = w_res.retransmit;
    assign o_res.resend_seq      = w_res.resend_seq;
    assign o_res.resend_offset   = w_res.resend_offset;
    assign o_res.delivered_bytes = w_res.delivered_bytes;
    assign o_res.unexpected      = w_res.unexpected;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for reno_congestion_window_fsm_top
// Feeds ACK and timeout events through the event channel and checks every
// window update against a cycle-free predictor of the congestion window
// state machine. The run opens with a directed table covering the field
// extremes, every event class, the clamp and the invalid
// events. It follows with random phases under different threshold and
// margin settings, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import rcw_pkg::*;

    localparam int unsigned MSS          = 1024;
    localparam int unsigned WIN_MAX      = 131071;
    localparam logic [FLD_W-1:0] ONES    = 32'hFFFF_FFFF;
    localparam int unsigned N_RANDOM     = 1200;
    localparam int          N_PHASES     = 6;
    // slowest event is a new ACK in avoidance, which waits on the divider
    localparam int          DRAIN_CYCLES = 40;
    // about 1220 events, each with at worst a sender gap, a divide and
    // a receiver stall; the limit is several times that over
    localparam int unsigned CYCLE_LIMIT  = 600000;

    typedef struct {
        t_evt_item item;
        bit        typed;
        t_res_item want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rcw_evt_if evt_ch ();
    rcw_res_if res_ch ();

    reno_congestion_window_fsm_top #(
        .MSS_BYTES (MSS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_evt      (evt_ch),
        .o_res      (res_ch)
    );

    // Predictor state: a private copy of the controller registers
    t_phase            cwnd_phase;
    logic [WIN_W-1:0]  cwnd;
    logic [WIN_W-1:0]  ssthresh;
    logic [DUP_W-1:0]  dup_acks;
    logic [FLD_W-1:0]  held_seq;
    logic [FLD_W-1:0]  held_len;
    logic [FLD_W-1:0]  held_off;
    logic [FLD_W-1:0]  held_tot;
    logic              unexp_seen;
    logic [WIN_W-1:0]  reload_thr;
    logic [MARGIN_W-1:0] clamp_mg;

    t_res_item   pending_updates[$];
    int unsigned fail_count;
    int unsigned cycles;
    int          burst_left;
    int          stall_left;
    int          stall_mode;

    // Clock
    always #5 i_clk = ~i_clk;

    // Watchdog: give up well past the slowest legal run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Saturate a window into 1 .. 17-bit max
    function automatic logic [WIN_W-1:0] bound_window(int unsigned w);
        if (w == 0) return WIN_W'(1);
        if (w > WIN_MAX) return WIN_W'(WIN_MAX);
        return WIN_W'(w);
    endfunction

    // Grow the window; once it reaches the threshold, pull it back to the threshold less the margin
    function automatic void grow_cwnd(int unsigned inc);
        int unsigned w;
        w = int'(cwnd) + inc;
        if (w >= int'(ssthresh))
            w = (ssthresh > clamp_mg) ? int'(ssthresh) - int'(clamp_mg) : 1;
        cwnd = bound_window(w);
    endfunction

    // Classify one event, update the window state and return the update
    function automatic t_res_item next_window_update(t_evt_item it);
        t_event    ev;
        t_phase    nxt;
        logic      clr;
        logic      rtx;
        t_res_item r;
        nxt = cwnd_phase;
        clr = 1'b0;
        rtx = 1'b0;
        if (it.operation == OP_TIMEOUT)
            ev = EV_TIMEOUT;
        else if (cwnd >= ssthresh)
            ev = EV_OVER;
        else if (dup_acks == DUP_THIRD)
            ev = EV_DUP3;
        else if (it.ack_seq == held_seq && it.ack_len == held_len &&
                 it.ack_offset == held_off && it.ack_total == held_tot)
            ev = EV_DUP;
        else begin
            ev       = EV_NEW;
            held_seq = it.ack_seq;
            held_len = it.ack_len;
            held_off = it.ack_offset;
            held_tot = it.ack_total;
            clr      = 1'b1;
        end

        case (ev)
            EV_NEW: begin
                case (cwnd_phase)
                    PH_FR: begin
                        cwnd = bound_window(int'(ssthresh));
                        nxt  = PH_CA;
                    end
                    PH_CA: grow_cwnd((MSS * MSS) / int'(cwnd));
                    default: grow_cwnd(MSS);
                endcase
                dup_acks = '0;
            end
            EV_TIMEOUT: begin
                ssthresh = cwnd >> 1;
                cwnd     = bound_window(MSS);
                dup_acks = '0;
                rtx      = 1'b1;
                clr      = 1'b1;
                nxt      = PH_SS;
            end
            EV_DUP: begin
                if (cwnd_phase == PH_FR) begin
                    grow_cwnd(MSS);
                    clr = 1'b1;
                end else begin
                    if (dup_acks != DUP_SAT) dup_acks = dup_acks + 1'b1;
                    rtx = 1'b1;
                end
            end
            EV_DUP3: begin
                rtx = 1'b1;
                if (cwnd_phase == PH_FR) begin
                    unexp_seen = 1'b1;
                end else begin
                    ssthresh = cwnd >> 1;
                    cwnd     = bound_window(int'(ssthresh) + 3 * MSS);
                    clr      = 1'b1;
                    nxt      = PH_FR;
                end
            end
            default: begin
                if (cwnd_phase == PH_SS) begin
                    cwnd     = bound_window(MSS);
                    ssthresh = reload_thr;
                    dup_acks = '0;
                    clr      = 1'b1;
                    nxt      = PH_CA;
                end else begin
                    unexp_seen = 1'b1;
                end
            end
        endcase
        cwnd_phase = nxt;

        r.event_code      = ev;
        r.phase           = cwnd_phase;
        r.window          = cwnd;
        r.threshold       = ssthresh;
        r.dup_count       = dup_acks;
        r.clear_inflight  = clr;
        r.retransmit      = rtx;
        r.resend_seq      = held_seq + 32'd1;
        r.resend_offset   = held_off;
        r.delivered_bytes = held_tot;
        r.unexpected      = unexp_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_evt_item ack_of(logic [FLD_W-1:0] s, logic [FLD_W-1:0] l,
                                         logic [FLD_W-1:0] o, logic [FLD_W-1:0] t);
        t_evt_item it;
        it.operation  = OP_ACK;
        it.ack_seq    = s;
        it.ack_len    = l;
        it.ack_offset = o;
        it.ack_total  = t;
        return it;
    endfunction

    // Timeout tick; its ACK fields carry junk that must be ignored
    function automatic t_evt_item tick();
        t_evt_item it;
        it = ack_of($urandom(), $urandom(), $urandom(), $urandom());
        it.operation = OP_TIMEOUT;
        return it;
    endfunction

    function automatic t_res_item upd_of(t_event ev, t_phase ph, int unsigned win,
                                         int unsigned thr, int unsigned dup, bit clr,
                                         bit rtx, logic [FLD_W-1:0] rseq,
                                         logic [FLD_W-1:0] roff, logic [FLD_W-1:0] del,
                                         bit unx);
        t_res_item r;
        r.event_code      = ev;
        r.phase           = ph;
        r.window          = WIN_W'(win);
        r.threshold       = WIN_W'(thr);
        r.dup_count       = DUP_W'(dup);
        r.clear_inflight  = clr;
        r.retransmit      = rtx;
        r.resend_seq      = rseq;
        r.resend_offset   = roff;
        r.delivered_bytes = del;
        r.unexpected      = unx;
        return r;
    endfunction

    // Random event biased towards well-formed ACK streams: mostly fresh ACKs
    // and exact repeats of the last distinct ACK, some near repeats that
    // differ in a single bit of one field, timeouts and a little noise
    function automatic t_evt_item make_item();
        t_evt_item   it;
        int unsigned roll;
        int unsigned bitpos;
        roll   = $urandom_range(0, 99);
        bitpos = $urandom_range(0, 31);
        it     = ack_of($urandom(), $urandom(), $urandom(), $urandom());
        if (roll < 7) begin
            it.operation = OP_TIMEOUT;
        end else if (roll < 45) begin
            it = ack_of(held_seq, held_len, held_off, held_tot);
            if (roll >= 37) begin
                case ($urandom_range(0, 3))
                    0: it.ack_seq[bitpos]    = ~it.ack_seq[bitpos];
                    1: it.ack_len[bitpos]    = ~it.ack_len[bitpos];
                    2: it.ack_offset[bitpos] = ~it.ack_offset[bitpos];
                    default: it.ack_total[bitpos] = ~it.ack_total[bitpos];
                endcase
            end
        end else if (roll >= 94) begin
            it.operation = 1'($urandom_range(0, 1));
        end
        return it;
    endfunction

    // Write both registers; only called with the block idle
    task automatic set_config(input logic [WIN_W-1:0] thr, input logic [MARGIN_W-1:0] mg);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_INIT_THR;
        i_cfg_data <= CFG_DATA_W'(thr);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_MARGIN;
        i_cfg_data <= CFG_DATA_W'(mg);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        reload_thr = thr;
        clamp_mg   = mg;
    endtask

    // Present one event, hold it until the transfer, then predict its update.
    // The sender runs in bursts; between bursts drop valid for a random gap.
    task automatic send_event(input t_evt_item it, input bit typed, input t_res_item want);
        int unsigned gap;
        t_res_item   upd;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 8);
            @(negedge i_clk);
            evt_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge i_clk);
        evt_ch.valid      <= 1'b1;
        evt_ch.operation  <= it.operation;
        evt_ch.ack_seq    <= it.ack_seq;
        evt_ch.ack_len    <= it.ack_len;
        evt_ch.ack_offset <= it.ack_offset;
        evt_ch.ack_total  <= it.ack_total;
        do @(posedge i_clk); while (evt_ch.ready !== 1'b1);
        upd = next_window_update(it);
        pending_updates.push_back(typed ? want : upd);
    endtask

    // Hold the sender off until every predicted update has been returned
    task automatic drain_updates();
        @(negedge i_clk);
        evt_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_updates.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern that changes mode whenever a random countdown
    // runs out (always ready, coin toss, mostly stalled, or a slow square wave)
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (stall_left <= 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 160);
            end
            stall_left--;
            case (stall_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= 1'($urandom_range(0, 1));
                2: res_ch.ready <= ($urandom_range(0, 3) == 0);
                default: res_ch.ready <= stall_left[2];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each returned update with the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [FLD_W-1:0] want_v,
                                        logic [FLD_W-1:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_res_item w;
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (pending_updates.size() == 0) begin
                $error("window update transfer with no event outstanding");
                fail_count++;
            end else begin
                w = pending_updates.pop_front();
                check_field("event_code",      w.event_code,      res_ch.event_code);
                check_field("phase",           w.phase,           res_ch.phase);
                check_field("window",          w.window,          res_ch.window);
                check_field("threshold",       w.threshold,       res_ch.threshold);
                check_field("dup_count",       w.dup_count,       res_ch.dup_count);
                check_field("clear_inflight",  w.clear_inflight,  res_ch.clear_inflight);
                check_field("retransmit",      w.retransmit,      res_ch.retransmit);
                check_field("resend_seq",      w.resend_seq,      res_ch.resend_seq);
                check_field("resend_offset",   w.resend_offset,   res_ch.resend_offset);
                check_field("delivered_bytes", w.delivered_bytes, res_ch.delivered_bytes);
                check_field("unexpected",      w.unexpected,      res_ch.unexpected);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_dir_row         rows[$];
        logic [WIN_W-1:0] thr;
        logic [MARGIN_W-1:0] mg;
        int               p;
        int               k;

        // Drive every input to a known value from time zero
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_INIT_THR;
        i_cfg_data        = '0;
        evt_ch.valid      = 1'b0;
        evt_ch.operation  = OP_ACK;
        evt_ch.ack_seq    = '0;
        evt_ch.ack_len    = '0;
        evt_ch.ack_offset = '0;
        evt_ch.ack_total  = '0;
        res_ch.ready      = 1'b0;
        fail_count        = 0;
        cycles            = 0;
        burst_left        = 0;
        stall_left        = 0;
        stall_mode        = 0;

        // Predictor after reset
        cwnd_phase = PH_SS;
        cwnd       = WIN_W'(MSS);
        ssthresh   = INIT_THR_RST;
        dup_acks   = '0;
        held_seq   = '0;
        held_len   = '0;
        held_off   = '0;
        held_tot   = '0;
        unexp_seen = 1'b0;
        reload_thr = INIT_THR_RST;
        clamp_mg   = MARGIN_RST;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, run under the reset settings. Typed rows can be
        // read straight off the rules; the rest lean on the predictor.
        // All-zero ACK matches the cleared last ACK: a duplicate straight away
        rows.push_back('{ack_of(0, 0, 0, 0), 1'b1,
            upd_of(EV_DUP, PH_SS, 1024, 65536, 1, 0, 1, 32'd1, 0, 0, 0)});
        // All-ones ACK: new, and the resend sequence wraps to zero
        rows.push_back('{ack_of(ONES, ONES, ONES, ONES), 1'b1,
            upd_of(EV_NEW, PH_SS, 2048, 65536, 0, 1, 0, 32'd0, ONES, ONES, 0)});
        // Three repeats count up the duplicates
        for (k = 0; k < 3; k++)
            rows.push_back('{ack_of(ONES, ONES, ONES, ONES), 1'b0, '0});
        // Count of three: third duplicate whatever the fields, into recovery
        rows.push_back('{ack_of(1, 2, 3, 4), 1'b1,
            upd_of(EV_DUP3, PH_FR, 4096, 1024, 3, 1, 1, 32'd0, ONES, ONES, 0)});
        // Window over threshold in recovery is invalid: only the flag moves
        rows.push_back('{ack_of(1, 2, 3, 4), 1'b1,
            upd_of(EV_OVER, PH_FR, 4096, 1024, 3, 0, 0, 32'd0, ONES, ONES, 1)});
        // Timeout out of recovery halves the window into the threshold
        rows.push_back('{tick(), 1'b1,
            upd_of(EV_TIMEOUT, PH_SS, 1024, 2048, 0, 1, 1, 32'd0, ONES, ONES, 1)});
        // One field differs at a time: each is a new ACK, growth hits the clamp
        rows.push_back('{ack_of(0, ONES, ONES, ONES), 1'b0, '0});
        rows.push_back('{ack_of(0, 0, ONES, ONES), 1'b0, '0});
        rows.push_back('{ack_of(0, 0, 0, ONES), 1'b0, '0});
        rows.push_back('{ack_of(0, 0, 0, 0), 1'b0, '0});
        rows.push_back('{ack_of(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                32'hAAAA_AAAA), 1'b0, '0});
        rows.push_back('{ack_of(32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                                32'h5555_5555), 1'b0, '0});
        // Timeout drops the threshold below the window, then over threshold
        // in slow start reloads it and moves to avoidance
        rows.push_back('{tick(), 1'b0, '0});
        rows.push_back('{ack_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000), 1'b0, '0});
        // Avoidance: new ACK growth, three duplicates, third duplicate
        rows.push_back('{ack_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF), 1'b0, '0});
        for (k = 0; k < 3; k++)
            rows.push_back('{ack_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF), 1'b0, '0});
        rows.push_back('{ack_of(9, 9, 9, 9), 1'b0, '0});
        rows.push_back('{tick(), 1'b0, '0});

        set_config(INIT_THR_RST, MARGIN_RST);
        foreach (rows[i])
            send_event(rows[i].item, rows[i].typed, rows[i].want);

        // Random phases, each under its own settings with the extremes first
        for (p = 0; p < N_PHASES; p++) begin
            drain_updates();
            case (p)
                0: begin thr = 17'd1024;  mg = 14'd0;    end
                1: begin thr = 17'd65536; mg = 14'd8192; end
                2: begin thr = 17'd1024;  mg = 14'd8192; end
                3: begin thr = 17'd65536; mg = 14'd0;    end
                default: begin
                    thr = WIN_W'($urandom_range(1024, 65536));
                    mg  = MARGIN_W'($urandom_range(0, 8192));
                end
            endcase
            set_config(thr, mg);
            repeat (N_RANDOM / N_PHASES) send_event(make_item(), 1'b0, '0);
        end

        // Wait out the last updates, then let the block settle
        drain_updates();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
design/rcw_pkg.sv
design/rcw_evt_if.sv
design/rcw_res_if.sv
design/rcw_div.sv
design/rcw_dp.sv
design/rcw_ctrl.sv
design/reno_congestion_window_fsm_top.sv
verif/tb.sv
